### sv/tds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants for the thread dispatch scheduler.
// ----------------------------------------------------------------------------
package tds_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = SLOT_W + 1;

	// request kinds
	typedef enum logic [2:0] {
		REQ_CREATE    = 3'd0,
		REQ_REMOVE    = 3'd1,
		REQ_WAIT      = 3'd2,
		REQ_SIGNAL    = 3'd3,
		REQ_RUN_TRIG  = 3'd4,
		REQ_TRIG_DONE = 3'd5,
		REQ_SWITCH    = 3'd6,
		REQ_TERMINATE = 3'd7
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_TABLE_FULL = 2'd1,
		ST_IGNORED    = 2'd2,
		ST_QUEUE_FULL = 2'd3
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture request fields
		logic exec;   // apply request, register result
	} tds_cmd_t;

endpackage

### sv/tds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_ctrl
// Request sequencer: accept, execute, hold the result until taken.
// ----------------------------------------------------------------------------
module tds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output tds_pkg::tds_cmd_t cmd
);
	import tds_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q, state_n;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_n = S_EXEC;
			S_EXEC: state_n = S_RESP;
			S_RESP: if (!out_stall) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign cmd.load  = (state_q == S_IDLE) && in_valid;
	assign cmd.exec  = (state_q == S_EXEC);

endmodule

### sv/tds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tds_datapath
// Slot table, runnable list, pending queue and the request update logic.
// ----------------------------------------------------------------------------
module tds_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tds_pkg::tds_cmd_t         cmd,
	input  logic [2:0]                req_type,
	input  logic [3:0]                thread_id,
	input  logic                      is_trigger,
	input  logic                      signal_lock,
	output logic [1:0]                status,
	output logic [3:0]                new_slot,
	output logic [3:0]                running_thread,
	output logic [4:0]                runnable_total
);
	import tds_pkg::*;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// captured request
	req_t       req_q;
	slot_t      id_q;
	logic       trig_req_q, lock_req_q;

	// scheduler state
	logic [MAX_SLOTS-1:0] alloc_q, run_q, trig_q, lock_q;
	slot_t list_q [MAX_SLOTS];
	slot_t pos_q  [MAX_SLOTS];
	slot_t pq_q   [MAX_SLOTS];
	cnt_t  rcnt_q, pcnt_q, used_q;
	logic  hold_v_q;
	slot_t hold_s_q, cur_q, rr_q;

	// next state
	logic [MAX_SLOTS-1:0] alloc_n, run_n, trig_n, lock_n;
	slot_t list_n [MAX_SLOTS];
	slot_t pos_n  [MAX_SLOTS];
	slot_t pq_n   [MAX_SLOTS];
	cnt_t  rcnt_n, pcnt_n, used_n;
	logic  hold_v_n;
	slot_t hold_s_n, cur_n, rr_n;
	status_t st_n;
	slot_t   given_n;

	// scratch
	logic  free_hit, pf_hit, do_rm, do_ins, do_hold;
	slot_t free_idx, pf_at, rm_s, ins_s, p, rr1;
	cnt_t  newc, rrx, rr_inc;

	// result registers
	logic [1:0] status_q;
	slot_t      new_slot_q, running_q;
	cnt_t       total_q;

	// lowest free slot from 1 upward
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = MAX_SLOTS - 1; i >= 1; i--) begin
			if (!alloc_q[i]) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// first pending entry holding the target slot
	always_comb begin
		pf_hit = 1'b0;
		pf_at  = '0;
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < pcnt_q) && (pq_q[i] == id_q)) begin
				pf_hit = 1'b1;
				pf_at  = SLOT_W'(i);
			end
		end
	end

	// request update
	always_comb begin
		alloc_n  = alloc_q;
		run_n    = run_q;
		trig_n   = trig_q;
		lock_n   = lock_q;
		list_n   = list_q;
		pos_n    = pos_q;
		pq_n     = pq_q;
		rcnt_n   = rcnt_q;
		pcnt_n   = pcnt_q;
		used_n   = used_q;
		hold_v_n = hold_v_q;
		hold_s_n = hold_s_q;
		cur_n    = cur_q;
		rr_n     = rr_q;
		st_n     = ST_DONE;
		given_n  = '0;
		do_rm    = 1'b0;
		rm_s     = cur_q;
		do_ins   = 1'b0;
		ins_s    = cur_q;
		do_hold  = 1'b0;
		p        = '0;
		newc     = '0;
		rrx      = '0;
		rr_inc   = CNT_W'(rr_q) + CNT_W'(1);
		rr1      = (rr_inc >= rcnt_q) ? '0 : rr_inc[SLOT_W-1:0];

		unique case (req_q)
			REQ_CREATE: begin
				if (used_q < CNT_W'(MAX_SLOTS) && free_hit) begin
					alloc_n[free_idx] = 1'b1;
					trig_n[free_idx]  = trig_req_q;
					lock_n[free_idx]  = trig_req_q ? 1'b0 : lock_req_q;
					run_n[free_idx]   = 1'b0;
					do_ins            = !trig_req_q;
					ins_s             = free_idx;
					used_n            = used_q + CNT_W'(1);
					given_n           = free_idx;
				end else begin
					st_n = ST_TABLE_FULL;
				end
			end
			REQ_REMOVE: begin
				if (id_q == '0 || id_q == cur_q || !alloc_q[id_q]) begin
					st_n = ST_IGNORED;
				end else begin
					do_rm          = 1'b1;
					rm_s           = id_q;
					alloc_n[id_q]  = 1'b0;
					lock_n[id_q]   = 1'b1;
					used_n         = used_q - CNT_W'(1);
					if (hold_v_q && hold_s_q == id_q) hold_v_n = 1'b0;
				end
			end
			REQ_WAIT: begin
				if (!run_q[cur_q]) st_n = ST_IGNORED;
				else do_rm = 1'b1;
			end
			REQ_SIGNAL: begin
				if (!alloc_q[id_q] || lock_q[id_q]) begin
					st_n = ST_IGNORED;
				end else if (pcnt_q >= CNT_W'(MAX_SLOTS)) begin
					st_n = ST_QUEUE_FULL;
				end else begin
					do_hold = 1'b1;
					if (pf_hit) begin
						// move the existing entry to the tail
						for (int i = 0; i < MAX_SLOTS - 1; i++) begin
							if (SLOT_W'(i) >= pf_at && CNT_W'(i + 1) < pcnt_q)
								pq_n[i] = pq_q[i + 1];
						end
						pq_n[SLOT_W'(pcnt_q - CNT_W'(1))] = id_q;
					end else begin
						pq_n[pcnt_q[SLOT_W-1:0]] = id_q;
						pcnt_n = pcnt_q + CNT_W'(1);
						do_ins = 1'b1;
					end
				end
			end
			REQ_RUN_TRIG: begin
				if (!alloc_q[id_q] || !trig_q[id_q] || run_q[id_q] || pf_hit) begin
					st_n = ST_IGNORED;
				end else if (pcnt_q >= CNT_W'(MAX_SLOTS)) begin
					st_n = ST_QUEUE_FULL;
				end else begin
					do_ins  = 1'b1;
					ins_s   = id_q;
					pq_n[pcnt_q[SLOT_W-1:0]] = id_q;
					pcnt_n  = pcnt_q + CNT_W'(1);
					do_hold = 1'b1;
				end
			end
			REQ_TRIG_DONE: begin
				if (!trig_q[cur_q] || !run_q[cur_q]) st_n = ST_IGNORED;
				else do_rm = 1'b1;
			end
			REQ_SWITCH: begin
				if (pcnt_q != '0) begin
					pcnt_n = pcnt_q - CNT_W'(1);
					cur_n  = pq_q[SLOT_W'(pcnt_q - CNT_W'(1))];
					pq_n[SLOT_W'(pcnt_q - CNT_W'(1))] = '0;
				end else if (hold_v_q) begin
					cur_n    = hold_s_q;
					hold_v_n = 1'b0;
				end else if (rcnt_q != '0) begin
					rr_n  = rr1;
					cur_n = list_q[rr1];
				end else begin
					st_n = ST_IGNORED;
				end
			end
			REQ_TERMINATE: begin
				if (cur_q == '0 || !alloc_q[cur_q]) begin
					st_n = ST_IGNORED;
				end else begin
					do_rm          = 1'b1;
					alloc_n[cur_q] = 1'b0;
					lock_n[cur_q]  = 1'b1;
					used_n         = used_q - CNT_W'(1);
					if (hold_v_q && hold_s_q == cur_q) hold_v_n = 1'b0;
				end
			end
			default: st_n = ST_IGNORED;
		endcase

		// current slot becomes the holding thread if none is held
		if (do_hold && !hold_v_q) begin
			hold_v_n = 1'b1;
			hold_s_n = cur_q;
		end

		// append to runnable list
		if (do_ins && !run_n[ins_s] && rcnt_q < CNT_W'(MAX_SLOTS)) begin
			list_n[rcnt_q[SLOT_W-1:0]] = ins_s;
			pos_n[ins_s]   = rcnt_q[SLOT_W-1:0];
			run_n[ins_s]   = 1'b1;
			rcnt_n         = rcnt_q + CNT_W'(1);
		end

		// remove from runnable list, close the gap, fix round-robin pointer
		if (do_rm && run_q[rm_s] && rcnt_q != '0) begin
			p    = (CNT_W'(pos_q[rm_s]) >= rcnt_q) ? SLOT_W'(rcnt_q - CNT_W'(1))
			                                       : pos_q[rm_s];
			newc = rcnt_q - CNT_W'(1);
			for (int i = 0; i < MAX_SLOTS - 1; i++) begin
				if (SLOT_W'(i) >= p && CNT_W'(i) < newc)
					list_n[i] = list_q[i + 1];
			end
			for (int t = 0; t < MAX_SLOTS; t++) begin
				if (run_q[t] && SLOT_W'(t) != rm_s && pos_q[t] > p)
					pos_n[t] = pos_q[t] - SLOT_W'(1);
			end
			run_n[rm_s] = 1'b0;
			pos_n[rm_s] = '0;
			rcnt_n      = newc;
			rrx         = CNT_W'(rr_q);
			if (newc == '0) begin
				rrx = '0;
			end else begin
				if (CNT_W'(p) <= rrx)
					rrx = (rr_q == '0) ? newc - CNT_W'(1) : rrx - CNT_W'(1);
				if (rrx >= newc) rrx = '0;
			end
			rr_n = rrx[SLOT_W-1:0];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= req_t'(req_type);
			id_q       <= thread_id;
			trig_req_q <= is_trigger;
			lock_req_q <= signal_lock;
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q  <= MAX_SLOTS'(1);
			run_q    <= MAX_SLOTS'(1);
			trig_q   <= '0;
			lock_q   <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				list_q[i] <= '0;
				pos_q[i]  <= '0;
				pq_q[i]   <= '0;
			end
			rcnt_q   <= CNT_W'(1);
			pcnt_q   <= '0;
			used_q   <= CNT_W'(1);
			hold_v_q <= 1'b0;
			hold_s_q <= '0;
			cur_q    <= '0;
			rr_q     <= '0;
		end else if (cmd.exec) begin
			alloc_q  <= alloc_n;
			run_q    <= run_n;
			trig_q   <= trig_n;
			lock_q   <= lock_n;
			list_q   <= list_n;
			pos_q    <= pos_n;
			pq_q     <= pq_n;
			rcnt_q   <= rcnt_n;
			pcnt_q   <= pcnt_n;
			used_q   <= used_n;
			hold_v_q <= hold_v_n;
			hold_s_q <= hold_s_n;
			cur_q    <= cur_n;
			rr_q     <= rr_n;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q   <= st_n;
			new_slot_q <= given_n;
			running_q  <= cur_n;
			total_q    <= rcnt_n;
		end
	end

	assign status         = status_q;
	assign new_slot       = new_slot_q;
	assign running_thread = running_q;
	assign runnable_total = total_q;

endmodule

### sv/thread_dispatch_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_dispatch_scheduler
// Round-robin hardware thread dispatcher with slot table, runnable list,
// LIFO pending queue and holding thread.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  request | in_valid / in_stall  | req_type, thread_id, is_trigger, signal_lock
//  result  | out_valid / out_stall| status, new_slot, running_thread,
//          |                      | runnable_total
//
// One request at a time: it is accepted, executed and its result presented,
// and the next request is accepted once the result is taken. The execute cycle
// applies the whole update in parallel over the slot entries.
// Reset restores slot 0 as the only allocated, runnable and current thread.
// A stalled result holds; no new request is taken until it is delivered.
module thread_dispatch_scheduler (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] req_type,
	input  logic [3:0] thread_id,
	input  logic       is_trigger,
	input  logic       signal_lock,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [3:0] new_slot,
	output logic [3:0] running_thread,
	output logic [4:0] runnable_total
);
	import tds_pkg::*;

	tds_cmd_t cmd;

	tds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tds_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.thread_id      (thread_id),
		.is_trigger     (is_trigger),
		.signal_lock    (signal_lock),
		.status         (status),
		.new_slot       (new_slot),
		.running_thread (running_thread),
		.runnable_total (runnable_total)
	);

`ifndef SYNTHESIS
	// an accepted request blocks the input until its result is out
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while busy");

	// result shown only after the execute cycle
	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall) && !$past(out_valid))
		else $error("result without execute cycle");

	// list never exceeds slot count
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> runnable_total <= 5'(MAX_SLOTS))
		else $error("runnable count out of range");
`endif

endmodule
